>>> sv/keyboard_hotkey_lock_filter_defines.svh
// Assertion helpers for the hotkey lock filter.
// Both expect signals named clk and arst_n in the module that uses them.
`ifndef KEYBOARD_HOTKEY_LOCK_FILTER_DEFINES_SVH
`define KEYBOARD_HOTKEY_LOCK_FILTER_DEFINES_SVH

// Same-cycle implication.
`define KHLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KHLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/khlf_pkg.sv
`default_nettype none

package khlf_pkg;

	localparam logic [7:0] VK_TAB   = 8'h09;
	localparam logic [7:0] KEY_SHIFT = 8'h10;
	localparam logic [7:0] VK_CTRL  = 8'h11;
	localparam logic [7:0] VK_ALT   = 8'h12;
	localparam logic [7:0] VK_ESC   = 8'h1B;
	localparam logic [7:0] VK_LWIN  = 8'h5B;
	localparam logic [7:0] VK_RWIN  = 8'h5C;
	localparam logic [7:0] VK_F1    = 8'h70;
	localparam logic [7:0] VK_F4    = 8'h73;
	localparam logic [7:0] VK_F12   = 8'h7B;
	localparam logic [7:0] KEY_LSHIFT = 8'hA0;
	localparam logic [7:0] KEY_RSHIFT = 8'hA1;
	localparam logic [7:0] VK_LCTRL  = 8'hA2;
	localparam logic [7:0] VK_RCTRL  = 8'hA3;
	localparam logic [7:0] VK_LALT   = 8'hA4;
	localparam logic [7:0] VK_RALT   = 8'hA5;

	// hotkey_modifiers bit positions
	localparam int MOD_CTRL_BIT  = 0;
	localparam int MOD_ALT_BIT   = 1;
	localparam int MOD_SHIFT_BIT = 2;
	localparam int MOD_WIN_BIT   = 3;

	localparam logic [1:0] ACT_DOWN = 2'd1;
	localparam logic [1:0] ACT_UP   = 2'd2;

	localparam logic FUNC_MOUSE = 1'b1;

	localparam logic [4:0] COMBO_NONE        = 5'd0;
	localparam logic [4:0] COMBO_WIN         = 5'd1;
	localparam logic [4:0] COMBO_WIN_BASE    = 5'd2;
	localparam logic [4:0] COMBO_ALT_TAB     = 5'd14;
	localparam logic [4:0] COMBO_ALT_F4      = 5'd15;
	localparam logic [4:0] COMBO_SHIFT_FBASE = 5'd16;

	localparam logic [1:0] CFG_HOTKEY_MODIFIERS = 2'd0;
	localparam logic [1:0] CFG_HOTKEY_KEY       = 2'd1;
	localparam logic [1:0] CFG_VIEWER_FORWARD   = 2'd2;

	localparam logic [3:0] HOTKEY_MODIFIERS_RST = 4'd7;
	localparam logic [7:0] HOTKEY_KEY_RST       = VK_F12;

	localparam int WIN_KEY_COUNT = 12;
	localparam logic [7:0] WIN_KEYS [WIN_KEY_COUNT] = '{
		8'h44, 8'h45, 8'h52, 8'h4C, VK_TAB, 8'h53,
		8'h49, 8'h58, 8'h56, 8'h41, 8'h47, 8'h50
	};

	typedef struct packed {
		logic       func;
		logic       hook_valid;
		logic [7:0] key_code;
		logic [1:0] key_action;
		logic       injected;
	} khlf_item_t;

	typedef struct packed {
		logic       swallow;
		logic [4:0] combo;
		logic       locked_now;
		logic       lock_changed;
	} khlf_result_t;

	typedef struct packed {
		logic ctrl_held;
		logic alt_held;
		logic shift_held;
		logic win_held;
		logic left_win_down;
		logic right_win_down;
		logic win_in_combo;
		logic lock_flag;
	} khlf_state_t;

	typedef struct packed {
		logic [3:0] hotkey_modifiers;
		logic [7:0] hotkey_key;
		logic       viewer_forward;
	} khlf_cfg_t;

	// Code of a win+key combination, COMBO_NONE if the key is not one we report.
	function automatic logic [4:0] win_combo_code(input logic [7:0] k);
		logic [4:0] code;
		code = COMBO_NONE;
		for (int i = WIN_KEY_COUNT - 1; i >= 0; i--) begin
			if (WIN_KEYS[i] == k) code = COMBO_WIN_BASE + 5'(i);
		end
		return code;
	endfunction

	function automatic logic is_fkey(input logic [7:0] k);
		return (k >= VK_F1) && (k <= VK_F12);
	endfunction

endpackage

`default_nettype wire

>>> sv/khlf_if.sv
`default_nettype none

interface khlf_in_if import khlf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       func;
	logic       hook_valid;
	logic [7:0] key_code;
	logic [1:0] key_action;
	logic       injected;

	modport source (output valid, func, hook_valid, key_code, key_action, injected,
		input ready);
	modport sink (input valid, func, hook_valid, key_code, key_action, injected,
		output ready);
endinterface

interface khlf_out_if import khlf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       swallow;
	logic [4:0] combo;
	logic       locked_now;
	logic       lock_changed;

	modport source (output valid, swallow, combo, locked_now, lock_changed, input ready);
	modport sink (input valid, swallow, combo, locked_now, lock_changed, output ready);
endinterface

interface khlf_cfg_if import khlf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/khlf_core.sv
`default_nettype none

// Per-event decision: result fields and next tracking state.
module khlf_core import khlf_pkg::*; (
	input  wire khlf_item_t   item,
	input  wire khlf_state_t  st,
	input  wire khlf_cfg_t    cfg,
	output khlf_result_t      res,
	output khlf_state_t       nxt
);

	always_comb begin
		logic       down;
		logic       up;
		logic       match;
		logic       fwd_sw;
		logic       any_win;
		logic [4:0] code;
		logic [7:0] k;

		k       = item.key_code;
		down    = (item.key_action == ACT_DOWN);
		up      = (item.key_action == ACT_UP);
		match   = 1'b0;
		fwd_sw  = 1'b0;
		code    = COMBO_NONE;
		any_win = st.left_win_down || st.right_win_down;
		nxt     = st;
		res     = '0;

		if (item.hook_valid && !item.injected) begin
			if (item.func == FUNC_MOUSE) begin
				res.swallow = st.lock_flag;
			end else begin
				// any action other than down clears the modifier
				if (k == VK_LCTRL || k == VK_RCTRL || k == VK_CTRL) begin
					nxt.ctrl_held = down;
				end else if (k == VK_LALT || k == VK_RALT || k == VK_ALT) begin
					nxt.alt_held = down;
				end else if (k == KEY_LSHIFT || k == KEY_RSHIFT || k == KEY_SHIFT) begin
					nxt.shift_held = down;
				end else if (k == VK_LWIN || k == VK_RWIN) begin
					nxt.win_held = down;
				end

				if (down && k == cfg.hotkey_key) begin
					match = (cfg.hotkey_modifiers[MOD_CTRL_BIT] == nxt.ctrl_held)
						&& (cfg.hotkey_modifiers[MOD_ALT_BIT] == nxt.alt_held)
						&& (cfg.hotkey_modifiers[MOD_SHIFT_BIT] == nxt.shift_held)
						&& (cfg.hotkey_modifiers[MOD_WIN_BIT] == nxt.win_held);
				end

				if (match) begin
					if (st.lock_flag) begin
						nxt.lock_flag  = 1'b0;
						nxt.ctrl_held  = 1'b0;
						nxt.alt_held   = 1'b0;
						nxt.shift_held = 1'b0;
						nxt.win_held   = 1'b0;
					end else begin
						nxt.lock_flag = 1'b1;
					end
					nxt.left_win_down  = 1'b0;
					nxt.right_win_down = 1'b0;
					nxt.win_in_combo   = 1'b0;
					res.lock_changed   = 1'b1;
					res.swallow        = 1'b1;
				end else begin
					if (cfg.viewer_forward && !st.lock_flag) begin
						if ((k == VK_LWIN || k == VK_RWIN) && (down || up)) begin
							fwd_sw = 1'b1;
							if (k == VK_LWIN) nxt.left_win_down = down;
							else nxt.right_win_down = down;
							if (down) nxt.win_in_combo = 1'b0;
							else if (!st.win_in_combo) code = COMBO_WIN;
						end else if (down) begin
							if (any_win) begin
								nxt.win_in_combo = 1'b1;
								code   = win_combo_code(k);
								fwd_sw = 1'b1;
							end else if (k == VK_ESC) begin
								fwd_sw = 1'b1;
							end else if (nxt.alt_held && k == VK_TAB) begin
								code   = COMBO_ALT_TAB;
								fwd_sw = 1'b1;
							end else if (nxt.alt_held && k == VK_F4) begin
								code   = COMBO_ALT_F4;
								fwd_sw = 1'b1;
							end else if (nxt.shift_held && !nxt.alt_held && !nxt.ctrl_held
								&& is_fkey(k)) begin
								code   = COMBO_SHIFT_FBASE + 5'(k - VK_F1);
								fwd_sw = 1'b1;
							end
						end else if (up) begin
							fwd_sw = any_win || nxt.alt_held || nxt.ctrl_held || (k == VK_ESC)
								|| (nxt.shift_held && is_fkey(k));
						end
					end
					res.combo   = fwd_sw ? code : COMBO_NONE;
					res.swallow = fwd_sw || st.lock_flag;
				end
			end
		end
		res.locked_now = nxt.lock_flag;
	end

endmodule

`default_nettype wire

>>> sv/keyboard_hotkey_lock_filter.sv
// Hotkey lock filter for keyboard and mouse events.
//
// Channels: ev (sink) carries one event per transaction; res (source) returns
// exactly one result per event, in order; cfg (sink) writes a register by
// index: 0 hotkey_modifiers, 1 hotkey_key, 2 viewer_forward. Other indexes are
// accepted and dropped. cfg.ready is always high; write only while idle.
//
// Timing: an accepted event lands in an input register, the decision logic
// sits between that register and the result register, so a result is offered
// once the event reaches the result register. One event per cycle is sustained
// while res.ready stays high; the modifier/lock flags are updated in the same
// cycle the result is registered, which lets the next event follow directly.
//
// Stall: while res.ready is low the result register holds and the input
// register keeps one more event; ev.ready drops only when both are full.
//
// Reset: unlocked, all modifier tracking clear, registers at their defaults
// (ctrl+alt+shift, F12, forwarding off), both stages empty.
`default_nettype none

module keyboard_hotkey_lock_filter import khlf_pkg::*; (
	input wire          clk,
	input wire          arst_n,
	khlf_cfg_if.sink    cfg,
	khlf_in_if.sink     ev,
	khlf_out_if.source  res
);

`include "keyboard_hotkey_lock_filter_defines.svh"

	khlf_item_t   item_s1;
	logic         valid_s1;
	khlf_result_t res_q;
	logic         res_valid_q;
	khlf_state_t  state_q;
	khlf_cfg_t    cfg_q;
	khlf_result_t core_res;
	khlf_state_t  core_nxt;
	logic         adv;
	logic         take_in;

	assign adv     = valid_s1 && (!res_valid_q || res.ready);
	assign ev.ready = !valid_s1 || adv;
	assign take_in = ev.valid && ev.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{hotkey_modifiers: HOTKEY_MODIFIERS_RST, hotkey_key: HOTKEY_KEY_RST,
				viewer_forward: 1'b0};
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_HOTKEY_MODIFIERS: cfg_q.hotkey_modifiers <= cfg.data[3:0];
				CFG_HOTKEY_KEY:       cfg_q.hotkey_key <= cfg.data;
				CFG_VIEWER_FORWARD:   cfg_q.viewer_forward <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ev.ready) begin
			valid_s1 <= ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{func: ev.func, hook_valid: ev.hook_valid, key_code: ev.key_code,
				key_action: ev.key_action, injected: ev.injected};
		end
	end

	khlf_core u_core (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.res  (core_res),
		.nxt  (core_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q     <= core_nxt;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= core_res;
	end

	assign res.valid        = res_valid_q;
	assign res.swallow      = res_q.swallow;
	assign res.combo        = res_q.combo;
	assign res.locked_now   = res_q.locked_now;
	assign res.lock_changed = res_q.lock_changed;

	`KHLF_ASSERT_NOW(a_change_swallows, res_valid_q && res_q.lock_changed, res_q.swallow, "lock toggle not swallowed")
	`KHLF_ASSERT_NOW(a_combo_swallows, res_valid_q && (res_q.combo != COMBO_NONE), res_q.swallow, "combo reported on a passed event")
	`KHLF_ASSERT_NEXT(a_toggle_flips, adv && core_res.lock_changed, state_q.lock_flag != $past(state_q.lock_flag), "lock flag did not toggle")
	`KHLF_ASSERT_NEXT(a_stalled_item_kept, valid_s1 && !adv, valid_s1 && $stable(item_s1), "stalled event lost")

endmodule

`default_nettype wire
